// ----- sv/efc_pkg.sv -----
// Package for the exact fraction compare unit.
// Holds the value width, the result codes and the controller/datapath types.
// No dependencies.
package efc_pkg;

    // Operand width used inside the block; input ports stay 64 bits wide.
    localparam int VALUE_WIDTH = 64;
    localparam int IN_WIDTH    = 64;
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

    // Order codes (2-bit signed)
    localparam logic signed [1:0] ORDER_LT = 2'sb11;
    localparam logic signed [1:0] ORDER_EQ = 2'sb00;
    localparam logic signed [1:0] ORDER_GT = 2'sb01;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_CMP
    } t_efc_state;

    // Controller to datapath
    typedef struct packed {
        logic load;        // capture a new transaction
        logic div_start;   // seed both dividers
        logic div_step;    // one quotient bit on both dividers
        logic swap;        // move to the reciprocal remainders
        logic finish_cmp;  // post the decided order
        logic finish_zd;   // post the zero-denominator result
    } t_efc_cmd;

    // Datapath to controller
    typedef struct packed {
        logic zero_den;    // a denominator is zero
        logic decided;     // current round settles the order
        logic out_free;    // result register can take a new result
    } t_efc_sts;

endpackage

// ----- sv/efc_ctrl.sv -----
// Controller for the exact fraction compare unit.
// Sequences the continued-fraction rounds and the bit-serial divisions.
// Depends on efc_pkg.
module efc_ctrl import efc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_efc_sts i_sts,
    output t_efc_cmd o_cmd
);

    t_efc_state r_state, n_state;
    logic [CNT_WIDTH-1:0] r_cnt, n_cnt;
    logic                 cnt_last;

    assign cnt_last = (r_cnt == CNT_WIDTH'(VALUE_WIDTH - 1));

    // State and bit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!i_sts.zero_den)      n_state = S_DIV;
                else if (i_sts.out_free)  n_state = S_IDLE;
            end
            S_DIV: begin
                if (cnt_last) n_state = S_CMP;
            end
            S_CMP: begin
                if (!i_sts.decided)       n_state = S_CHECK;
                else if (i_sts.out_free)  n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and commands
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_CHECK: begin
                if (!i_sts.zero_den) begin
                    o_cmd.div_start = 1'b1;
                    n_cnt           = '0;
                end else begin
                    o_cmd.finish_zd = i_sts.out_free;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_WIDTH'(1);
            end
            S_CMP: begin
                if (!i_sts.decided) o_cmd.swap       = 1'b1;
                else                o_cmd.finish_cmp = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- sv/efc_dp.sv -----
// Datapath for the exact fraction compare unit: operand registers, two
// restoring bit-serial dividers, round compare and the result register.
// Depends on efc_pkg.
module efc_dp import efc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_efc_cmd            i_cmd,
    output t_efc_sts            o_sts,
    input  logic [IN_WIDTH-1:0] i_num_left,
    input  logic [IN_WIDTH-1:0] i_den_left,
    input  logic [IN_WIDTH-1:0] i_num_right,
    input  logic [IN_WIDTH-1:0] i_den_right,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [1:0]   o_order,
    output logic                o_zero_denominator
);

    localparam int W = VALUE_WIDTH;

    logic [W-1:0] r_n1, r_d1, r_n2, r_d2;
    logic [W-1:0] r_rem1, r_rem2, r_quo1, r_quo2;
    logic         r_neg;                 // sense of the answer is flipped
    logic         r_valid;
    logic signed [1:0] r_order;
    logic         r_zd;

    logic [W:0]   sh1, sh2, diff1, diff2;
    logic         ge1, ge2;
    logic         q_ne, q_lt, r1_zero, r2_zero;
    logic signed [1:0] cmp_order;

    // One restoring step on each divider
    assign sh1   = {r_rem1, r_quo1[W-1]};
    assign sh2   = {r_rem2, r_quo2[W-1]};
    assign diff1 = sh1 - {1'b0, r_d1};
    assign diff2 = sh2 - {1'b0, r_d2};
    assign ge1   = (sh1 >= {1'b0, r_d1});
    assign ge2   = (sh2 >= {1'b0, r_d2});

    // Round compare on finished quotients and remainders
    assign q_ne    = (r_quo1 != r_quo2);
    assign q_lt    = (r_quo1 < r_quo2);
    assign r1_zero = (r_rem1 == '0);
    assign r2_zero = (r_rem2 == '0);

    always_comb begin
        if (q_ne)
            cmp_order = (q_lt ^ r_neg) ? ORDER_LT : ORDER_GT;
        else if (r1_zero && r2_zero)
            cmp_order = ORDER_EQ;
        else if (r1_zero)
            cmp_order = r_neg ? ORDER_GT : ORDER_LT;
        else
            cmp_order = r_neg ? ORDER_LT : ORDER_GT;
    end

    assign o_sts.zero_den = (r_d1 == '0) || (r_d2 == '0);
    assign o_sts.decided  = q_ne || r1_zero || r2_zero;
    assign o_sts.out_free = !r_valid || i_ready;

    // Operands and dividers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n1  <= i_num_left[W-1:0];
            r_d1  <= i_den_left[W-1:0];
            r_n2  <= i_num_right[W-1:0];
            r_d2  <= i_den_right[W-1:0];
            r_neg <= 1'b0;
        end else if (i_cmd.swap) begin
            r_n1  <= r_d2;
            r_d1  <= r_rem2;
            r_n2  <= r_d1;
            r_d2  <= r_rem1;
            r_neg <= !r_neg;
        end
        if (i_cmd.div_start) begin
            r_rem1 <= '0;
            r_rem2 <= '0;
            r_quo1 <= r_n1;
            r_quo2 <= r_n2;
        end else if (i_cmd.div_step) begin
            r_rem1 <= ge1 ? diff1[W-1:0] : sh1[W-1:0];
            r_rem2 <= ge2 ? diff2[W-1:0] : sh2[W-1:0];
            r_quo1 <= {r_quo1[W-2:0], ge1};
            r_quo2 <= {r_quo2[W-2:0], ge2};
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.finish_cmp || i_cmd.finish_zd) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish_zd) begin
            r_order <= ORDER_EQ;
            r_zd    <= 1'b1;
        end else if (i_cmd.finish_cmp) begin
            r_order <= cmp_order;
            r_zd    <= 1'b0;
        end
    end

    assign o_valid            = r_valid;
    assign o_order            = r_order;
    assign o_zero_denominator = r_zd;

endmodule

// ----- sv/exact_fraction_compare_unit.sv -----
// Exact fraction compare unit: orders num_left/den_left against
// num_right/den_right by continued-fraction expansion, no multipliers.
// Depends on efc_pkg, efc_ctrl and efc_dp.
//
// Usage:
//   Input channel i_valid/o_ready carries one transaction of four 64-bit
//   operands; VALUE_WIDTH low bits of each are used. Output channel
//   o_valid/i_ready returns o_order (-1, 0, +1) and o_zero_denominator.
//   Each round runs two restoring dividers in parallel, one quotient bit
//   per cycle. A transaction takes up to about 93 rounds for 64-bit
//   operands; a zero denominator finishes without any division round.
//   One transaction is worked on at a time; the next is taken as soon as
//   the result sits in the output register, even if unread.
//   If the receiver stalls with a result still held, the block waits at the
//   end of the following transaction until the register frees up.
//   Synchronous active-low reset clears the controller and output valid;
//   no result is pending after reset.
module exact_fraction_compare_unit import efc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [IN_WIDTH-1:0] i_num_left,
    input  logic [IN_WIDTH-1:0] i_den_left,
    input  logic [IN_WIDTH-1:0] i_num_right,
    input  logic [IN_WIDTH-1:0] i_den_right,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [1:0]   o_order,
    output logic                o_zero_denominator
);

    t_efc_cmd cmd;
    t_efc_sts sts;

    // Sequencer
    efc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Operands, dividers and result register
    efc_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_num_left         (i_num_left),
        .i_den_left         (i_den_left),
        .i_num_right        (i_num_right),
        .i_den_right        (i_den_right),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_order            (o_order),
        .o_zero_denominator (o_zero_denominator)
    );

endmodule
